FILE: rtl/eqhc_pkg.sv
// Shared constants, types and helper functions for the equatorial/horizontal converter.
`default_nettype none

package eqhc_pkg;

	// angle field width; 2^ANGLE_BITS LSBs make one full turn
	localparam int ANGLE_BITS = 24;
	localparam int FRAC_SHIFT = 32 - ANGLE_BITS;

	// CORDIC, square-root and normalise step counts
	localparam int CORDIC_ITERS = 30;
	localparam int SQRT_ITERS = 31;
	localparam int NORM_STEPS = 5;

	// internal widths
	localparam int Z_W = 35;   // angle accumulator, 2^32 per turn
	localparam int VEC_W = 33; // Q30 sine and cosine values
	localparam int T_W = 32;   // clamped sine term
	localparam int RT_W = 62;  // square-root radicand and root
	localparam int AV_W = 36;  // vectoring CORDIC components

	typedef logic signed [ANGLE_BITS-1:0] ang_t;
	typedef logic signed [Z_W-1:0] zang_t;
	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [AV_W-1:0] avec_t;
	typedef logic [RT_W-1:0] rt_t;

	localparam vec_t CORDIC_GAIN = VEC_W'(652032874);
	localparam zang_t Z_QUARTER = Z_W'(64'sd1 <<< 30);
	localparam zang_t Z_HALF = Z_W'(64'sd1 <<< 31);
	localparam zang_t ROUND_HALF = Z_W'((64'd1 << FRAC_SHIFT) >> 1);

	// arctangent of 2^-i, 2^32 units per turn, truncated
	function automatic zang_t atan_z(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2F9;
			15: v = 32'h0000517C;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A2F;
			19: v = 32'h00000517;
			20: v = 32'h0000028B;
			21: v = 32'h00000145;
			22: v = 32'h000000A2;
			23: v = 32'h00000051;
			24: v = 32'h00000028;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000002;
			29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return $signed({{(Z_W-32){1'b0}}, v});
	endfunction

	// Q30 product with floor shift
	function automatic vec_t mulq(input vec_t a, input vec_t b);
		logic signed [2*VEC_W-1:0] p;
		p = a * b;
		return p[VEC_W+29:30];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/equatorial_horizontal_convert_unit.sv
// Equatorial/horizontal coordinate converter: fully pipelined CORDIC datapath.
// The datapath holds 105 register stages from input to output.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Stages: input fold, 30 rotation CORDIC steps, unfold, 4 multiply/sum steps, root setup,
// 31 square-root steps, half-plane fold, 5 normalise steps, 30 vectoring steps, rounding.
// Reset (arst_n low) clears the valid bits and sets the latitude register to zero.
`default_nettype none

module equatorial_horizontal_convert_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  signed [eqhc_pkg::ANGLE_BITS-1:0] first_angle,
	input  wire  signed [eqhc_pkg::ANGLE_BITS-1:0] second_angle,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [eqhc_pkg::ANGLE_BITS-1:0] elevation_angle,
	output logic signed [eqhc_pkg::ANGLE_BITS-1:0] around_angle,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  signed [eqhc_pkg::ANGLE_BITS-1:0] latitude
);

	localparam int AW = eqhc_pkg::ANGLE_BITS;
	localparam int SH = eqhc_pkg::FRAC_SHIFT;
	localparam int CI = eqhc_pkg::CORDIC_ITERS;
	localparam int SQ = eqhc_pkg::SQRT_ITERS;
	localparam int NM = eqhc_pkg::NORM_STEPS;
	localparam int ZW = eqhc_pkg::Z_W;
	localparam int VW = eqhc_pkg::VEC_W;
	localparam int TW = eqhc_pkg::T_W;
	localparam int RW = eqhc_pkg::RT_W;
	localparam int AVW = eqhc_pkg::AV_W;

	// stage positions in the valid chain
	localparam int ST_UNF = CI + 1;
	localparam int ST_AF = ST_UNF + 5 + SQ;
	localparam int NST = ST_AF + 1 + (NM + 1) + CI + 1;

	localparam logic signed [VW:0] T_ONE = (VW+1)'(64'sd1 <<< 30);
	localparam eqhc_pkg::zang_t EL_MAX = ZW'(64'sd1 <<< (AW - 2));

	logic            adv;
	logic [NST-1:0]  vld_q;
	eqhc_pkg::ang_t  latitude_q;

	// pipeline moves unless a finished item is held at the output
	assign adv       = !(vld_q[NST-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[NST-1];
	assign cfg_ready = 1'b1;

	// latitude register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latitude_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			latitude_q <= latitude;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// ---------------- rotation CORDIC: sin/cos of three angles ----------------
	// lane 0: first angle, lane 1: second angle, lane 2: latitude
	eqhc_pkg::vec_t  sc_x_s   [3][CI+1];
	eqhc_pkg::vec_t  sc_y_s   [3][CI+1];
	eqhc_pkg::zang_t sc_z_s   [3][CI+1];
	logic            sc_neg_s [3][CI+1];
	eqhc_pkg::ang_t  ang_in   [3];
	eqhc_pkg::zang_t th_in    [3];

	always_comb begin
		ang_in[0] = first_angle;
		ang_in[1] = second_angle;
		ang_in[2] = latitude_q;
		for (int l = 0; l < 3; l++) begin
			th_in[l] = ZW'(ang_in[l]) <<< SH;
		end
	end

	// input stage: fold into [-1/4, 1/4] turn
	for (genvar l = 0; l < 3; l++) begin : g_sc_fold
		always_ff @(posedge clk) begin
			if (adv) begin
				sc_x_s[l][0] <= eqhc_pkg::CORDIC_GAIN;
				sc_y_s[l][0] <= '0;
				if (th_in[l] > eqhc_pkg::Z_QUARTER) begin
					sc_z_s[l][0]   <= th_in[l] - eqhc_pkg::Z_HALF;
					sc_neg_s[l][0] <= 1'b1;
				end else if (th_in[l] < -eqhc_pkg::Z_QUARTER) begin
					sc_z_s[l][0]   <= th_in[l] + eqhc_pkg::Z_HALF;
					sc_neg_s[l][0] <= 1'b1;
				end else begin
					sc_z_s[l][0]   <= th_in[l];
					sc_neg_s[l][0] <= 1'b0;
				end
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_sc_lane
		for (genvar i = 0; i < CI; i++) begin : g_sc_step
			always_ff @(posedge clk) begin
				if (adv) begin
					sc_neg_s[l][i+1] <= sc_neg_s[l][i];
					if (!sc_z_s[l][i][ZW-1]) begin
						sc_x_s[l][i+1] <= sc_x_s[l][i] - (sc_y_s[l][i] >>> i);
						sc_y_s[l][i+1] <= sc_y_s[l][i] + (sc_x_s[l][i] >>> i);
						sc_z_s[l][i+1] <= sc_z_s[l][i] - eqhc_pkg::atan_z(i);
					end else begin
						sc_x_s[l][i+1] <= sc_x_s[l][i] + (sc_y_s[l][i] >>> i);
						sc_y_s[l][i+1] <= sc_y_s[l][i] - (sc_x_s[l][i] >>> i);
						sc_z_s[l][i+1] <= sc_z_s[l][i] + eqhc_pkg::atan_z(i);
					end
				end
			end
		end
	end

	// undo the half-turn fold
	eqhc_pkg::vec_t uf_cos_s [3];
	eqhc_pkg::vec_t uf_sin_s [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				uf_cos_s[l] <= sc_neg_s[l][CI] ? -sc_x_s[l][CI] : sc_x_s[l][CI];
				uf_sin_s[l] <= sc_neg_s[l][CI] ? -sc_y_s[l][CI] : sc_y_s[l][CI];
			end
		end
	end

	// ---------------- products ----------------
	eqhc_pkg::vec_t m1_c1c2_s, m1_y_s, m1_p1_s, m1_p2_s, m1_c3_s, m1_s3_s;
	eqhc_pkg::vec_t m2_a_s, m2_b_s, m2_y_s, m2_p1_s, m2_p2_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_c1c2_s <= eqhc_pkg::mulq(uf_cos_s[0], uf_cos_s[1]);
			m1_y_s    <= eqhc_pkg::mulq(uf_sin_s[0], uf_cos_s[1]);
			m1_p1_s   <= eqhc_pkg::mulq(uf_sin_s[1], uf_sin_s[2]);
			m1_p2_s   <= eqhc_pkg::mulq(uf_sin_s[1], uf_cos_s[2]);
			m1_c3_s   <= uf_cos_s[2];
			m1_s3_s   <= uf_sin_s[2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m2_a_s  <= eqhc_pkg::mulq(m1_c1c2_s, m1_c3_s);
			m2_b_s  <= eqhc_pkg::mulq(m1_c1c2_s, m1_s3_s);
			m2_y_s  <= m1_y_s;
			m2_p1_s <= m1_p1_s;
			m2_p2_s <= m1_p2_s;
		end
	end

	// sine term with clamp, and the atan2 numerator/denominator
	logic signed [VW:0]    t_sum;
	logic signed [TW-1:0]  m3_t_s;
	logic signed [VW:0]    m3_x_s;
	eqhc_pkg::vec_t        m3_y_s;

	assign t_sum = (VW+1)'(m2_a_s) + (VW+1)'(m2_p1_s);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (t_sum > T_ONE) begin
				m3_t_s <= TW'(T_ONE);
			end else if (t_sum < -T_ONE) begin
				m3_t_s <= TW'(-T_ONE);
			end else begin
				m3_t_s <= TW'(t_sum);
			end
			m3_x_s <= (VW+1)'(m2_p2_s) - (VW+1)'(m2_b_s);
			m3_y_s <= m2_y_s;
		end
	end

	// t squared
	logic signed [2*TW-1:0] t_sq;
	eqhc_pkg::rt_t          sq_t2_s;
	logic signed [TW-1:0]   sq_t_s;
	logic signed [VW:0]     sq_x_s;
	eqhc_pkg::vec_t         sq_y_s;

	assign t_sq = m3_t_s * m3_t_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_t2_s <= t_sq[RW-1:0];
			sq_t_s  <= m3_t_s;
			sq_x_s  <= m3_x_s;
			sq_y_s  <= m3_y_s;
		end
	end

	// ---------------- square root of 1 - t^2, one result bit per stage ----------------
	eqhc_pkg::rt_t        rt_v_s [SQ+1];
	eqhc_pkg::rt_t        rt_r_s [SQ+1];
	logic signed [TW-1:0] rt_t_s [SQ+1];
	logic signed [VW:0]   rt_x_s [SQ+1];
	eqhc_pkg::vec_t       rt_y_s [SQ+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_v_s[0] <= (RW'(1) << 60) - sq_t2_s;
			rt_r_s[0] <= '0;
			rt_t_s[0] <= sq_t_s;
			rt_x_s[0] <= sq_x_s;
			rt_y_s[0] <= sq_y_s;
		end
	end

	for (genvar k = 0; k < SQ; k++) begin : g_rt_step
		localparam eqhc_pkg::rt_t RT_BIT = RW'(1) << (60 - 2*k);
		eqhc_pkg::rt_t rb;
		assign rb = rt_r_s[k] + RT_BIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rt_v_s[k] >= rb) begin
					rt_v_s[k+1] <= rt_v_s[k] - rb;
					rt_r_s[k+1] <= (rt_r_s[k] >> 1) + RT_BIT;
				end else begin
					rt_v_s[k+1] <= rt_v_s[k];
					rt_r_s[k+1] <= rt_r_s[k] >> 1;
				end
				rt_t_s[k+1] <= rt_t_s[k];
				rt_x_s[k+1] <= rt_x_s[k];
				rt_y_s[k+1] <= rt_y_s[k];
			end
		end
	end

	// ---------------- vectoring CORDIC: lane 0 elevation, lane 1 around ----------------
	eqhc_pkg::avec_t af_x_in [2];
	eqhc_pkg::avec_t af_y_in [2];

	always_comb begin
		af_x_in[0] = $signed({1'b0, rt_r_s[SQ][AVW-2:0]});
		af_y_in[0] = AVW'(rt_t_s[SQ]);
		af_x_in[1] = AVW'(rt_x_s[SQ]);
		af_y_in[1] = AVW'(rt_y_s[SQ]);
	end

	// nm index 0 is the half-plane fold, then the normalising shifts
	eqhc_pkg::avec_t nm_x_s    [2][NM+1];
	eqhc_pkg::avec_t nm_y_s    [2][NM+1];
	eqhc_pkg::zang_t nm_z_s    [2][NM+1];
	logic            nm_zero_s [NM+1];

	for (genvar l = 0; l < 2; l++) begin : g_nm_fold
		always_ff @(posedge clk) begin
			if (adv) begin
				if (af_x_in[l][AVW-1]) begin
					nm_x_s[l][0] <= -af_x_in[l];
					nm_y_s[l][0] <= -af_y_in[l];
					nm_z_s[l][0] <= eqhc_pkg::Z_HALF;
				end else begin
					nm_x_s[l][0] <= af_x_in[l];
					nm_y_s[l][0] <= af_y_in[l];
					nm_z_s[l][0] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_zero_s[0] <= (af_x_in[1] == '0) && (af_y_in[1] == '0);
		end
	end

	// double both components while both stay below 2^29, searched 16/8/4/2/1
	for (genvar j = 0; j < NM; j++) begin : g_nm_step
		localparam int NS = (1 << (NM - 1)) >> j;
		localparam eqhc_pkg::avec_t LIM = AVW'(64'sd1 <<< (30 - NS));
		for (genvar l = 0; l < 2; l++) begin : g_nm_lane
			logic fits;
			assign fits = (nm_x_s[l][j] < LIM) && (nm_y_s[l][j] < LIM)
				&& (nm_y_s[l][j] > -LIM);
			always_ff @(posedge clk) begin
				if (adv) begin
					nm_x_s[l][j+1] <= fits ? (nm_x_s[l][j] <<< NS) : nm_x_s[l][j];
					nm_y_s[l][j+1] <= fits ? (nm_y_s[l][j] <<< NS) : nm_y_s[l][j];
					nm_z_s[l][j+1] <= nm_z_s[l][j];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				nm_zero_s[j+1] <= nm_zero_s[j];
			end
		end
	end

	eqhc_pkg::avec_t vc_x_s    [2][CI+1];
	eqhc_pkg::avec_t vc_y_s    [2][CI+1];
	eqhc_pkg::zang_t vc_z_s    [2][CI+1];
	logic            vc_zero_s [CI+1];

	for (genvar l = 0; l < 2; l++) begin : g_vc_init
		always_comb begin
			vc_x_s[l][0] = nm_x_s[l][NM];
			vc_y_s[l][0] = nm_y_s[l][NM];
			vc_z_s[l][0] = nm_z_s[l][NM];
		end
	end

	always_comb begin
		vc_zero_s[0] = nm_zero_s[NM];
	end

	for (genvar i = 0; i < CI; i++) begin : g_vc_step
		for (genvar l = 0; l < 2; l++) begin : g_vc_lane
			always_ff @(posedge clk) begin
				if (adv) begin
					if (vc_y_s[l][i][AVW-1]) begin
						vc_x_s[l][i+1] <= vc_x_s[l][i] - (vc_y_s[l][i] >>> i);
						vc_y_s[l][i+1] <= vc_y_s[l][i] + (vc_x_s[l][i] >>> i);
						vc_z_s[l][i+1] <= vc_z_s[l][i] - eqhc_pkg::atan_z(i);
					end else begin
						vc_x_s[l][i+1] <= vc_x_s[l][i] + (vc_y_s[l][i] >>> i);
						vc_y_s[l][i+1] <= vc_y_s[l][i] - (vc_x_s[l][i] >>> i);
						vc_z_s[l][i+1] <= vc_z_s[l][i] + eqhc_pkg::atan_z(i);
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				vc_zero_s[i+1] <= vc_zero_s[i];
			end
		end
	end

	// ---------------- rounding to the output width ----------------
	eqhc_pkg::zang_t el_rnd, ar_rnd;

	assign el_rnd = (vc_z_s[0][CI] + eqhc_pkg::ROUND_HALF) >>> SH;
	assign ar_rnd = (vc_z_s[1][CI] + eqhc_pkg::ROUND_HALF) >>> SH;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (el_rnd > EL_MAX) begin
				elevation_angle <= AW'(EL_MAX);
			end else if (el_rnd < -EL_MAX) begin
				elevation_angle <= AW'(-EL_MAX);
			end else begin
				elevation_angle <= el_rnd[AW-1:0];
			end
			around_angle <= vc_zero_s[CI] ? '0 : ar_rnd[AW-1:0];
		end
	end

	// ---------------- assertions ----------------
	a_el_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (elevation_angle <= AW'(EL_MAX)) && (elevation_angle >= AW'(-EL_MAX)))
		else $error("elevation outside quarter turn");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted item missing from first stage");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire
